@@ sv/isp_pkg.sv @@
// isp_pkg: widths, register indexes and the multiply-divide request type
// for the integral separation pid block; no dependencies
`timescale 1ns / 1ps

package isp_pkg;

  localparam int ERR_BITS   = 16;
  localparam int DRIVE_BITS = 32;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int A_W        = ERR_BITS + 2;
  localparam int PROD_W     = A_W + 2 * GAIN_W;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam int ACC_W      = ((PROD_W > DRIVE_BITS) ? PROD_W : DRIVE_BITS) + 3;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [1:0] REG_INTEG_TIME  = 2'd1;
  localparam logic [1:0] REG_DERIV_TIME  = 2'd2;
  localparam logic [1:0] REG_INTEG_LIMIT = 2'd3;

  typedef struct packed {
    logic [A_W-1:0]    mag;
    logic [GAIN_W-1:0] mul_a;
    logic [GAIN_W-1:0] mul_b;
    logic [GAIN_W-1:0] divisor;
  } md_req_t;

endpackage

@@ sv/isp_if.sv @@
// isp_in_if / isp_out_if: valid-ready channels for sample and drive words
// depends on isp_pkg
`timescale 1ns / 1ps

interface isp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [isp_pkg::ERR_BITS-1:0] err_sample;
  logic [15:0]                         period;
  modport source (output valid, output err_sample, output period, input ready);
  modport sink (input valid, input err_sample, input period, output ready);
endinterface

interface isp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [isp_pkg::DRIVE_BITS-1:0] drive;
  logic                                  saturated;
  modport source (output valid, output drive, output saturated, input ready);
  modport sink (input valid, input drive, input saturated, output ready);
endinterface

@@ sv/isp_muldiv.sv @@
// isp_muldiv: bit-serial |a| * x * y / d, truncating, zero when d is zero
// depends on isp_pkg
`timescale 1ns / 1ps

module isp_muldiv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  isp_pkg::md_req_t          req_i,
  output logic                      done_o,
  output logic [isp_pkg::PROD_W-1:0] quot_o
);
  import isp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_DIV} state_e;

  state_e              state_q;
  logic [PROD_W-1:0]   acc_q, mcand_q;
  logic [GAIN_W-1:0]   mplier_q, mulb_q, dvs_q, rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                done_q;
  logic [PROD_W-1:0]   sum;
  logic [GAIN_W:0]     trial;
  logic                ge;

  assign sum   = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign trial = {rem_q, acc_q[PROD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      mulb_q   <= '0;
      dvs_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
    end else begin
      done_q <= (state_q == S_DIV) && (cnt_q == CNT_W'(PROD_W - 1));
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            acc_q    <= '0;
            mcand_q  <= PROD_W'(req_i.mag);
            mplier_q <= req_i.mul_a;
            mulb_q   <= req_i.mul_b;
            dvs_q    <= req_i.divisor;
            cnt_q    <= '0;
            state_q  <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (cnt_q == CNT_W'(GAIN_W - 1)) begin
            mcand_q  <= sum;
            acc_q    <= '0;
            mplier_q <= mulb_q;
            cnt_q    <= '0;
            state_q  <= S_MUL2;
          end else begin
            acc_q    <= sum;
            mcand_q  <= mcand_q << 1;
            mplier_q <= mplier_q >> 1;
            cnt_q    <= cnt_q + 1'b1;
          end
        end
        S_MUL2: begin
          acc_q    <= sum;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          if (cnt_q == CNT_W'(GAIN_W - 1)) begin
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          rem_q <= ge ? GAIN_W'(trial - {1'b0, dvs_q}) : GAIN_W'(trial);
          acc_q <= {acc_q[PROD_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(PROD_W - 1)) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = (dvs_q == '0) ? '0 : acc_q;

endmodule

@@ sv/integral_separation_pid.sv @@
// integral_separation_pid: pid with integral separation, one drive word per sample word
// from sample word to drive word, the three terms pass in turn through the
// bit-serial multiply-divide unit (issue, two multiply passes, a divide, handoff),
// then the sum is saturated into the output register
// one sample word in flight at a time; output stalls hold the input
// async active-low reset: first-sample phase, history, drive cleared, registers to defaults
`timescale 1ns / 1ps

module integral_separation_pid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  isp_in_if.sink                      in_i,
  isp_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isp_pkg::PADDR_W-1:0] paddr,
  input  logic [isp_pkg::PDATA_W-1:0] pwdata,
  output logic [isp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import isp_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN} state_e;

  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_RUN    = 2'd3;
  localparam logic [1:0] TERM_P    = 2'd0;
  localparam logic [1:0] TERM_I    = 2'd1;
  localparam logic [1:0] TERM_D    = 2'd2;
  localparam logic signed [ACC_W-1:0] DMAX = (ACC_W'(1) <<< (DRIVE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] DMIN = -DMAX - 1;

  state_e                     state_q;
  logic [1:0]                 phase_q, term_q;
  logic [GAIN_W-1:0]          kp_q, ti_q, td_q, t_q;
  logic [LIMIT_W-1:0]         limit_q;
  logic signed [ERR_BITS-1:0] e_q, err1_q, err2_q;
  logic signed [DRIVE_BITS-1:0] dacc_q, drive_q;
  logic signed [ACC_W-1:0]    acc_q, term_s;
  logic                       neg_q, sat_q, out_valid_q;
  logic signed [A_W-1:0]      e_a, e1_a, e2_a, oper;
  logic                       qe, qe1, md_done;
  logic [GAIN_W-1:0]          mulb, dvs;
  logic [PROD_W-1:0]          quot;
  md_req_t                    req;
  logic                       cfg_wr;

  function automatic logic qual(input logic signed [A_W-1:0] x,
                                input logic [LIMIT_W-1:0] lim);
    logic [A_W-1:0] m;
    m = x[A_W-1] ? A_W'(-x) : A_W'(x);
    return m <= A_W'(lim);
  endfunction

  assign e_a  = A_W'(e_q);
  assign e1_a = A_W'(err1_q);
  assign e2_a = A_W'(err2_q);
  assign qe   = qual(e_a, limit_q);
  assign qe1  = qual(e1_a, limit_q);

  always_comb begin
    oper = '0;
    mulb = GAIN_W'(1);
    dvs  = GAIN_W'(1);
    case (term_q)
      TERM_P: oper = (phase_q == PH_FIRST || phase_q == PH_SECOND) ? e_a : e_a - e1_a;
      TERM_I: begin
        mulb = t_q;
        dvs  = ti_q;
        if (phase_q == PH_SECOND)
          oper = (qe ? e_a : '0) + (qe1 ? e1_a : '0);
        else
          oper = qe ? e_a : '0;
      end
      TERM_D: begin
        mulb = td_q;
        dvs  = t_q;
        if (phase_q == PH_FIRST)
          oper = '0;
        else if (phase_q == PH_SECOND)
          oper = e_a - e1_a;
        else
          oper = e_a - (e1_a <<< 1) + e2_a;
      end
      default: oper = '0;
    endcase
    req.mag     = oper[A_W-1] ? A_W'(-oper) : A_W'(oper);
    req.mul_a   = kp_q;
    req.mul_b   = mulb;
    req.divisor = dvs;
  end

  isp_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_ISSUE),
    .req_i   (req),
    .done_o  (md_done),
    .quot_o  (quot)
  );

  assign term_s = $signed(ACC_W'(quot));

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_PROP_GAIN:   prdata = PDATA_W'(kp_q);
      REG_INTEG_TIME:  prdata = PDATA_W'(ti_q);
      REG_DERIV_TIME:  prdata = PDATA_W'(td_q);
      REG_INTEG_LIMIT: prdata = PDATA_W'(limit_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= GAIN_W'(256);
      ti_q    <= GAIN_W'(1000);
      td_q    <= '0;
      limit_q <= LIMIT_W'(32767);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PROP_GAIN:   kp_q    <= pwdata[GAIN_W-1:0];
        REG_INTEG_TIME:  ti_q    <= pwdata[GAIN_W-1:0];
        REG_DERIV_TIME:  td_q    <= pwdata[GAIN_W-1:0];
        REG_INTEG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.drive     = drive_q;
  assign out_o.saturated = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      term_q      <= TERM_P;
      err1_q      <= '0;
      err2_q      <= '0;
      dacc_q      <= '0;
      out_valid_q <= 1'b0;
      e_q         <= '0;
      t_q         <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      drive_q     <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            e_q     <= in_i.err_sample;
            t_q     <= in_i.period;
            term_q  <= TERM_P;
            acc_q   <= (phase_q == PH_FIRST || phase_q == PH_SECOND) ? '0 : ACC_W'(dacc_q);
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          neg_q   <= oper[A_W-1];
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (md_done) begin
            acc_q <= neg_q ? acc_q - term_s : acc_q + term_s;
            if (term_q == TERM_D) begin
              state_q <= ST_FIN;
            end else begin
              term_q  <= term_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            if (acc_q > DMAX) begin
              drive_q <= DRIVE_BITS'(DMAX);
              dacc_q  <= DRIVE_BITS'(DMAX);
              sat_q   <= 1'b1;
            end else if (acc_q < DMIN) begin
              drive_q <= DRIVE_BITS'(DMIN);
              dacc_q  <= DRIVE_BITS'(DMIN);
              sat_q   <= 1'b1;
            end else begin
              drive_q <= DRIVE_BITS'(acc_q);
              dacc_q  <= DRIVE_BITS'(acc_q);
              sat_q   <= 1'b0;
            end
            out_valid_q <= 1'b1;
            err2_q      <= err1_q;
            err1_q      <= e_q;
            if (phase_q == PH_FIRST)       phase_q <= PH_SECOND;
            else if (phase_q == PH_SECOND) phase_q <= PH_RUN;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/isp_checker.sv @@
// isp_checker: watches the sample, drive and register channels of integral_separation_pid,
// predicts each drive word and compares it; depends on isp_pkg and isp_if
`timescale 1ns / 1ps

module isp_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  isp_in_if                           in_w,
  isp_out_if                          out_w,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isp_pkg::PADDR_W-1:0] paddr,
  input  logic [isp_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_cnt_o,
  output int                          pending_o,
  output int                          taken_cnt_o,
  output int                          sat_cnt_o
);
  import isp_pkg::*;

  typedef struct {
    logic signed [DRIVE_BITS-1:0] drive;
    logic                         saturated;
  } drive_word_t;

  localparam logic signed [63:0] TERM_MAX = 64'sd1 <<< 60;
  localparam logic signed [63:0] DRV_MAX  = (64'sd1 <<< (DRIVE_BITS - 1)) - 1;
  localparam logic signed [63:0] DRV_MIN  = -DRV_MAX - 1;

  logic [GAIN_W-1:0]  kp, ti, td;
  logic [LIMIT_W-1:0] lim;
  logic [1:0]         step_phase;
  logic signed [63:0] e1, e2, drive_acc;
  drive_word_t        drive_q[$];

  // a * b / d with the sign of a, magnitude truncated toward zero and clamped, zero when d is zero
  function automatic logic signed [63:0] scale_div(logic signed [63:0] a, logic [63:0] b,
                                                   logic [63:0] d);
    logic          neg;
    logic [127:0]  mag, quo;
    logic [63:0]   res;
    if (d == 0) return 0;
    neg = a < 0;
    mag = {64'd0, neg ? -a : a};
    quo = (mag * {64'd0, b}) / {64'd0, d};
    res = (quo > TERM_MAX) ? TERM_MAX : quo[63:0];
    return neg ? -$signed(res) : $signed(res);
  endfunction

  function automatic logic in_band(logic signed [63:0] e);
    logic signed [63:0] m;
    m = e < 0 ? -e : e;
    return m <= $signed({49'd0, lim});
  endfunction

  function automatic logic signed [63:0] integ(logic signed [63:0] esum, logic [63:0] t);
    if (ti == 0) return 0;
    return scale_div(esum, {48'd0, kp} * t, {48'd0, ti});
  endfunction

  function automatic logic signed [63:0] deriv(logic signed [63:0] ediff, logic [63:0] t);
    if (t == 0) return 0;
    return scale_div(ediff, {48'd0, kp} * {48'd0, td}, t);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [63:0] e, total, esum;
    logic [63:0]        t;
    drive_word_t        w, got;
    if (!rst_ni) begin
      kp <= 16'd256; ti <= 16'd1000; td <= 16'd0; lim <= 15'h7fff;
      step_phase <= 2'd1; e1 <= 0; e2 <= 0; drive_acc <= 0;
      drive_q.delete();
      fail_cnt_o <= 0; taken_cnt_o <= 0; sat_cnt_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PROP_GAIN:   kp  <= pwdata[15:0];
          REG_INTEG_TIME:  ti  <= pwdata[15:0];
          REG_DERIV_TIME:  td  <= pwdata[15:0];
          REG_INTEG_LIMIT: lim <= pwdata[14:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        e = in_w.err_sample;
        t = {48'd0, in_w.period};
        if (step_phase == 2'd1) begin
          total = scale_div(e, {48'd0, kp}, 1);
          if (in_band(e)) total += integ(e, t);
          step_phase <= 2'd2;
        end else if (step_phase == 2'd2) begin
          esum = 0;
          if (in_band(e)) esum += e;
          if (in_band(e1)) esum += e1;
          total = scale_div(e, {48'd0, kp}, 1) + integ(esum, t) + deriv(e - e1, t);
          step_phase <= 2'd3;
        end else begin
          total = drive_acc + scale_div(e - e1, {48'd0, kp}, 1)
                + deriv(e - 2 * e1 + e2, t);
          if (in_band(e)) total += integ(e, t);
        end
        w.saturated = 1'b0;
        if (total > DRV_MAX) begin total = DRV_MAX; w.saturated = 1'b1; end
        if (total < DRV_MIN) begin total = DRV_MIN; w.saturated = 1'b1; end
        w.drive = total[DRIVE_BITS-1:0];
        e2 <= e1; e1 <= e; drive_acc <= total;
        drive_q.push_back(w);
        taken_cnt_o <= taken_cnt_o + 1;
        if (w.saturated) sat_cnt_o <= sat_cnt_o + 1;
      end
      if (out_w.valid && out_w.ready) begin
        got.drive = out_w.drive;
        got.saturated = out_w.saturated;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected drive word %h sat %b", $time, got.drive, got.saturated);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          w = drive_q.pop_front();
          if (got.drive !== w.drive || got.saturated !== w.saturated) begin
            $display("%0t: drive mismatch, expected %h sat %b, actual %h sat %b",
                     $time, w.drive, w.saturated, got.drive, got.saturated);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = drive_q.size();

endmodule

@@ tb/integral_separation_pid_test.sv @@
// integral_separation_pid_test: stimulus, register settings and verdict for integral_separation_pid
// depends on isp_pkg, isp_if, isp_checker and the block itself
`timescale 1ns / 1ps

module integral_separation_pid_test;
  import isp_pkg::*;

  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 175;
  localparam int QUIET_ITEMS = 200;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_WAIT  = 300;
  localparam int STUCK_LIMIT = 20000;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int   fail_cnt, pending, taken_cnt, sat_cnt;
  int   sent, stuck, cfg_writes;
  logic quiet;

  isp_in_if  in_w();
  isp_out_if out_w();

  integral_separation_pid dut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_w.sink), .out_o(out_w.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  isp_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_w(in_w), .out_w(out_w),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_cnt_o(fail_cnt), .pending_o(pending),
    .taken_cnt_o(taken_cnt), .sat_cnt_o(sat_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("integral_separation_pid verification failed");
      $finish;
    end
  end

  // drive word receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    int   gap;
    logic held;
    held = 1'b0;
    out_w.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && taken_cnt >= 400) begin
        held = 1'b1;
        out_w.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        out_w.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_w.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic signed [ERR_BITS-1:0] e, logic [15:0] t);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_w.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_w.valid <= 1'b1;
    in_w.err_sample <= e;
    in_w.period <= t;
    do @(posedge clk); while (!in_w.ready);
    sent++;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cfg_writes++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_w.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_gains(logic [15:0] kp_v, logic [15:0] ti_v, logic [15:0] td_v,
                           logic [14:0] lim_v);
    settle();
    reg_write(REG_PROP_GAIN, kp_v);
    reg_write(REG_INTEG_TIME, ti_v);
    reg_write(REG_DERIV_TIME, td_v);
    reg_write(REG_INTEG_LIMIT, {1'b0, lim_v});
  endtask

  function automatic logic [15:0] pick16(logic [15:0] lo);
    case ($urandom_range(0, 4))
      0: return lo;
      1: return 16'hffff;
      2: return 16'($urandom_range(lo, 64));
      default: return 16'($urandom_range(lo, 65535));
    endcase
  endfunction

  initial begin
    logic [14:0] lim_r;
    logic signed [ERR_BITS-1:0] e;
    int m;
    rst_n = 1'b0; quiet = 1'b0; sent = 0; cfg_writes = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_w.valid = 1'b0; in_w.err_sample = '0; in_w.period = 16'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // positional pi, positional pid, then incremental words at reset gains
    send_word(-16'sd32768, 16'hffff);
    send_word(16'sd32767, 16'd1);
    send_word(16'sd0, 16'd1);
    send_word(16'sd32767, 16'hffff);
    // maximum gains, nothing integrated: saturation both ways
    set_gains(16'hffff, 16'd1, 16'hffff, 15'd0);
    send_word(16'sd32767, 16'd1);
    send_word(16'sd32767, 16'd1);
    send_word(-16'sd32768, 16'd1);
    send_word(-16'sd32768, 16'hffff);
    send_word(16'sd1, 16'd1);
    // band edges of the integral separation
    set_gains(16'd256, 16'd4, 16'd3, 15'd100);
    send_word(16'sd100, 16'd7);
    send_word(-16'sd100, 16'd7);
    send_word(16'sd101, 16'd7);
    send_word(-16'sd101, 16'd7);
    send_word(16'sd0, 16'd65535);
    // zero gain and full band
    set_gains(16'd0, 16'hffff, 16'd0, 15'h7fff);
    send_word(16'sd32767, 16'd1);
    send_word(-16'sd32768, 16'd1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) set_gains(16'd0, 16'd1, 16'd0, 15'd0);
      else if (p == 1) set_gains(16'hffff, 16'hffff, 16'hffff, 15'h7fff);
      else begin
        lim_r = ($urandom_range(0, 2) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
        set_gains($urandom_range(0, 1) ? 16'($urandom_range(0, 1024)) : pick16(16'd0),
                  pick16(16'd1), pick16(16'd0), lim_r);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == RAND_PHASES - 1 && i >= PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
        case ($urandom_range(0, 5))
          0: e = ERR_BITS'($urandom);
          1: e = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
          2: begin
            m = $urandom_range(0, 2100);
            e = $urandom_range(0, 1) ? 16'(m) : 16'(-m);
          end
          default: e = 16'($signed($urandom_range(0, 1024)) - 512);
        endcase
        send_word(e, pick16(16'd1));
      end
    end

    settle();
    $display("%0d sample words in %0d gain settings (%0d register writes), %0d saturated",
             sent, RAND_PHASES + 4, cfg_writes, sat_cnt);
    $display("covered first, second and incremental forms, band edges and long output stall");
    if (fail_cnt == 0 && pending == 0) begin
      $display("integral_separation_pid verification clean");
    end else begin
      $display("integral_separation_pid verification failed");
    end
    $finish;
  end

endmodule
